// File: sv/zero_export_power_setpoint_top_defines.svh
// Assertion macros for the zero-export power setpoint block.
// Included by the controller and datapath; expects clk and rst in scope.
`ifndef ZERO_EXPORT_POWER_SETPOINT_TOP_DEFINES_SVH
`define ZERO_EXPORT_POWER_SETPOINT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ZEPS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zeps: %m check failed");
`define ZEPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zeps: %m check failed");
`else
`define ZEPS_ASSERT_IMP(label, ante, cons)
`define ZEPS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: sv/zeps_pkg.sv
// Shared types and constants for the zero-export power setpoint block.
// No dependencies; used by all interfaces and modules of the block.
package zeps_pkg;

  localparam int GAIN_PERCENT = 100;
  localparam int PCT_SCALE    = 100;

  localparam int STAMP_W  = 32;
  localparam int GRID_W   = 16;
  localparam int GEXT_W   = GRID_W + 1;
  localparam int DEM_W    = 14;
  localparam int TGT_W    = 16;
  localparam int SRC_W    = 3;
  localparam int CNT_W    = 5;
  localparam int TOL_W    = 10;
  localparam int PWR_W    = 16;
  localparam int MAXP_W   = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // |grid| * gain needs 22 bits; count * 100 needs 12 bits
  localparam int NUM_W      = 22;
  localparam int DEN_W      = 12;
  localparam int SUM_W      = 19;
  localparam int DIV_CNT_W  = $clog2(NUM_W);

  typedef enum logic [SRC_W-1:0] {
    SRC_STOP      = 3'd0,
    SRC_STATIC    = 3'd1,
    SRC_FALLBACK  = 3'd2,
    SRC_REGULATED = 3'd3,
    SRC_HELD      = 3'd4
  } src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATIC_MODE   = 3'd0,
    CFG_STATIC_POWER  = 3'd1,
    CFG_FALLBACK_PWR  = 3'd2,
    CFG_INV_COUNT     = 3'd3,
    CFG_IMPORT_TOL    = 3'd4,
    CFG_EXPORT_TOL    = 3'd5,
    CFG_MAX_POWER     = 3'd6,
    CFG_NIGHT_MAX     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic              static_mode;
    logic [PWR_W-1:0]  static_power_w;
    logic [PWR_W-1:0]  fallback_power_w;
    logic [CNT_W-1:0]  inverter_count;
    logic [TOL_W-1:0]  import_tolerance_w;
    logic [TOL_W-1:0]  export_tolerance_w;
    logic [MAXP_W-1:0] max_power_w;
    logic [MAXP_W-1:0] night_max_power_w;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_sts_t;

endpackage

// File: sv/zeps_tick_if.sv
// Request channel carrying one regulation tick.
// Depends on zeps_pkg for field widths.
interface zeps_tick_if;
  import zeps_pkg::*;
  logic               valid;
  logic               ready;
  logic               emergency_stop;
  logic               fallback_active;
  logic               night_mode;
  logic [STAMP_W-1:0] measurement_stamp;
  logic [GRID_W-1:0]  grid_power_w;
  logic [DEM_W-1:0]   current_demand_w;

  modport source (output valid, emergency_stop, fallback_active, night_mode,
                  measurement_stamp, grid_power_w, current_demand_w, input ready);
  modport sink (input valid, emergency_stop, fallback_active, night_mode,
                measurement_stamp, grid_power_w, current_demand_w, output ready);
endinterface

// File: sv/zeps_setpoint_if.sv
// Request channel carrying one per-inverter setpoint result.
// Depends on zeps_pkg for field widths.
interface zeps_setpoint_if;
  import zeps_pkg::*;
  logic             valid;
  logic             ready;
  logic [TGT_W-1:0] target_power_w;
  logic [SRC_W-1:0] target_source;

  modport source (output valid, target_power_w, target_source, input ready);
  modport sink (input valid, target_power_w, target_source, output ready);
endinterface

// File: sv/zeps_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on zeps_pkg for field widths.
interface zeps_cfg_if;
  import zeps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/zeps_regs.sv
// Configuration register file, written through the configuration channel.
// Depends on zeps_pkg for cfg_t and register indexes.
module zeps_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [zeps_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [zeps_pkg::CFG_DATA_W-1:0] wr_data,
  output zeps_pkg::cfg_t                 cfg
);
  import zeps_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.static_mode        <= 1'b0;
      cfg.static_power_w     <= '0;
      cfg.fallback_power_w   <= '0;
      cfg.inverter_count     <= CNT_W'(1);
      cfg.import_tolerance_w <= '0;
      cfg.export_tolerance_w <= '0;
      cfg.max_power_w        <= '1;
      cfg.night_max_power_w  <= '1;
    end else if (wr_valid) begin
      case (cfg_idx_t'(wr_index))
        CFG_STATIC_MODE:  cfg.static_mode        <= wr_data[0];
        CFG_STATIC_POWER: cfg.static_power_w     <= wr_data[PWR_W-1:0];
        CFG_FALLBACK_PWR: cfg.fallback_power_w   <= wr_data[PWR_W-1:0];
        CFG_INV_COUNT:    cfg.inverter_count     <= wr_data[CNT_W-1:0];
        CFG_IMPORT_TOL:   cfg.import_tolerance_w <= wr_data[TOL_W-1:0];
        CFG_EXPORT_TOL:   cfg.export_tolerance_w <= wr_data[TOL_W-1:0];
        CFG_MAX_POWER:    cfg.max_power_w        <= wr_data[MAXP_W-1:0];
        CFG_NIGHT_MAX:    cfg.night_max_power_w  <= wr_data[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/zeps_ctrl.sv
// Sequencing state machine: accept, decide, divide, finish.
// Depends on zeps_pkg and the assertion macro header.
`include "zero_export_power_setpoint_top_defines.svh"
module zeps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  zeps_pkg::dp_sts_t sts,
  output zeps_pkg::dp_cmd_t cmd
);
  import zeps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_FIN
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.decide = (state == S_DECIDE);
  assign cmd.step   = (state == S_DIV);
  assign cmd.finish = (state == S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.need_div) begin
            state <= S_DIV;
            cnt   <= DIV_CNT_W'(NUM_W - 1);
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt == '0) state <= S_FIN;
          else cnt <= cnt - DIV_CNT_W'(1);
        end
        S_FIN: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `ZEPS_ASSERT_NXT(a_accept_decide, in_valid && in_ready, state == S_DECIDE)
  `ZEPS_ASSERT_IMP(a_result_from_fin, $rose(out_valid), $past(state == S_FIN))
  `ZEPS_ASSERT_NXT(a_div_ends, state == S_DIV && cnt == '0, state == S_FIN)

endmodule

// File: sv/zeps_dp.sv
// Datapath: input latch, mode select, shared restoring divider, clamps,
// regulation state and the result register. Depends on zeps_pkg and the macro header.
`include "zero_export_power_setpoint_top_defines.svh"
module zeps_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  zeps_pkg::cfg_t               cfg,
  input  zeps_pkg::dp_cmd_t            cmd,
  output zeps_pkg::dp_sts_t            sts,
  input  logic                         emergency_stop,
  input  logic                         fallback_active,
  input  logic                         night_mode,
  input  logic [zeps_pkg::STAMP_W-1:0] measurement_stamp,
  input  logic [zeps_pkg::GRID_W-1:0]  grid_power_w,
  input  logic [zeps_pkg::DEM_W-1:0]   current_demand_w,
  output logic [zeps_pkg::TGT_W-1:0]   target_power_w,
  output logic [zeps_pkg::SRC_W-1:0]   target_source
);
  import zeps_pkg::*;

  logic               estop_q;
  logic               fallback_q;
  logic               night_q;
  logic [STAMP_W-1:0] stamp_q;
  logic [GRID_W-1:0]  grid_q;
  logic [DEM_W-1:0]   demand_q;

  src_t               src_q;
  logic               neg_q;
  logic [NUM_W-1:0]   quo;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den;

  logic [STAMP_W-1:0] last_stamp;
  logic [DEM_W-1:0]   last_target;

  logic [CNT_W-1:0]        count_eff;
  logic signed [GEXT_W-1:0] grid_ext;
  logic signed [GEXT_W-1:0] imp_s;
  logic signed [GEXT_W-1:0] exp_s;
  logic [GEXT_W-1:0]       grid_mag;
  logic                    correct;
  src_t                    src_sel;
  logic [NUM_W-1:0]        num_sel;
  logic [DEN_W-1:0]        den_sel;

  logic [DEN_W:0]          shifted;
  logic                    fits;

  logic signed [SUM_W-1:0] q_s;
  logic signed [SUM_W-1:0] dem_s;
  logic signed [SUM_W-1:0] max_s;
  logic signed [SUM_W-1:0] sum;
  logic [DEM_W-1:0]        reg_tgt;
  logic [TGT_W-1:0]        pre_tgt;
  logic [TGT_W-1:0]        fin_tgt;

  assign count_eff = (cfg.inverter_count == '0) ? CNT_W'(1) : cfg.inverter_count;
  assign grid_ext  = $signed({grid_q[GRID_W-1], grid_q});
  assign imp_s     = $signed({{(GEXT_W-TOL_W){1'b0}}, cfg.import_tolerance_w});
  assign exp_s     = $signed({{(GEXT_W-TOL_W){1'b0}}, cfg.export_tolerance_w});
  assign grid_mag  = grid_q[GRID_W-1] ? GEXT_W'(-grid_ext) : GEXT_W'(grid_ext);
  assign correct   = (grid_ext >= imp_s) || (grid_ext <= -exp_s);

  always_comb begin
    if (estop_q) src_sel = SRC_STOP;
    else if (cfg.static_mode) src_sel = SRC_STATIC;
    else if (fallback_q) src_sel = SRC_FALLBACK;
    else if (stamp_q != last_stamp) src_sel = SRC_REGULATED;
    else src_sel = SRC_HELD;
  end

  always_comb begin
    case (src_sel)
      SRC_STATIC: begin
        num_sel = NUM_W'(cfg.static_power_w);
        den_sel = DEN_W'(count_eff);
      end
      SRC_FALLBACK: begin
        num_sel = NUM_W'(cfg.fallback_power_w);
        den_sel = DEN_W'(count_eff);
      end
      SRC_REGULATED: begin
        num_sel = correct ? NUM_W'(grid_mag * GAIN_PERCENT) : '0;
        den_sel = DEN_W'(count_eff * PCT_SCALE);
      end
      default: begin
        num_sel = '0;
        den_sel = DEN_W'(count_eff);
      end
    endcase
  end

  assign sts.need_div = (src_sel == SRC_STATIC) || (src_sel == SRC_FALLBACK) ||
                        (src_sel == SRC_REGULATED);

  assign shifted = {rem, quo[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den});

  assign q_s   = neg_q ? -$signed({{(SUM_W-GEXT_W){1'b0}}, quo[GEXT_W-1:0]})
                       : $signed({{(SUM_W-GEXT_W){1'b0}}, quo[GEXT_W-1:0]});
  assign dem_s = $signed({{(SUM_W-DEM_W){1'b0}}, demand_q});
  assign max_s = $signed({{(SUM_W-MAXP_W){1'b0}}, cfg.max_power_w});
  assign sum   = dem_s + q_s;

  always_comb begin
    if (sum < 0) reg_tgt = '0;
    else if (sum > max_s) reg_tgt = cfg.max_power_w;
    else reg_tgt = sum[DEM_W-1:0];
  end

  always_comb begin
    case (src_q)
      SRC_STATIC, SRC_FALLBACK: pre_tgt = quo[TGT_W-1:0];
      SRC_REGULATED:            pre_tgt = TGT_W'(reg_tgt);
      SRC_HELD:                 pre_tgt = TGT_W'(last_target);
      default:                  pre_tgt = '0;
    endcase
    fin_tgt = pre_tgt;
    if (night_q && (src_q != SRC_STOP) && (pre_tgt > TGT_W'(cfg.night_max_power_w)))
      fin_tgt = TGT_W'(cfg.night_max_power_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      estop_q    <= emergency_stop;
      fallback_q <= fallback_active;
      night_q    <= night_mode;
      stamp_q    <= measurement_stamp;
      grid_q     <= grid_power_w;
      demand_q   <= current_demand_w;
    end
    if (cmd.decide) begin
      src_q <= src_sel;
      neg_q <= grid_q[GRID_W-1];
      quo   <= num_sel;
      rem   <= '0;
      den   <= den_sel;
    end else if (cmd.step) begin
      quo <= {quo[NUM_W-2:0], fits};
      rem <= fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
    end
    if (cmd.finish) begin
      target_power_w <= fin_tgt;
      target_source  <= SRC_W'(src_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp  <= '0;
      last_target <= '0;
    end else if (cmd.finish && (src_q == SRC_REGULATED)) begin
      last_stamp  <= stamp_q;
      last_target <= reg_tgt;
    end
  end

  `ZEPS_ASSERT_NXT(a_stored_in_range, cmd.finish && src_q == SRC_REGULATED, last_target <= $past(cfg.max_power_w))
  `ZEPS_ASSERT_NXT(a_stop_zero, cmd.finish && src_q == SRC_STOP, target_power_w == '0)

endmodule

// File: sv/zero_export_power_setpoint_top.sv
// Top level of the zero-export power setpoint block.
// Depends on zeps_pkg, the channel interfaces, zeps_regs, zeps_ctrl and zeps_dp.
//
// One tick request yields one per-inverter setpoint with its source code.
// Ticks that need a division (static, fallback, new measurement) pass through
// the shared restoring divider, which produces one quotient bit per cycle
// over 22 bits; emergency stop and held ticks skip the divider.
// The result sits in an
// output register, so the next tick is accepted while a result waits to be
// taken. Configuration writes are taken every cycle.
module zero_export_power_setpoint_top (
  input logic       clk,
  input logic       rst,
  zeps_tick_if.sink       tick,
  zeps_setpoint_if.source setpoint,
  zeps_cfg_if.sink        cfg
);
  import zeps_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  zeps_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  zeps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (setpoint.valid),
    .out_ready (setpoint.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  zeps_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg_q),
    .cmd               (cmd),
    .sts               (sts),
    .emergency_stop    (tick.emergency_stop),
    .fallback_active   (tick.fallback_active),
    .night_mode        (tick.night_mode),
    .measurement_stamp (tick.measurement_stamp),
    .grid_power_w      (tick.grid_power_w),
    .current_demand_w  (tick.current_demand_w),
    .target_power_w    (setpoint.target_power_w),
    .target_source     (setpoint.target_source)
  );

endmodule
